/* rtl/core/ppl_pkg.sv */
package ppl_pkg;

  // Field widths of the pixel request and of the result.
  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int ANGLE_W = 9;
  localparam int LEVEL_W = 7;

  // Internal datapath widths.
  localparam int DEG_W   = 7;   // folded quarter-wave degree, 0..90
  localparam int FRAC_W  = 14;  // Q1.14 fraction bits
  localparam int MAG_W   = 15;  // Q1.14 magnitude, 0..16384
  localparam int COS_W   = 16;  // signed Q1.14 cosine
  localparam int DX_W    = 18;  // signed column offset in Q8
  localparam int DY_W    = 16;  // unsigned row offset in Q8
  localparam int DXSQ_W  = 33;
  localparam int DYSQ_W  = 32;
  localparam int RAD_W   = 34;  // squared distance, padded to an even width
  localparam int DIST_W  = 17;  // distance in Q9.8
  localparam int RES_W   = 34;  // residue of the phase division
  localparam int SUM_W   = 16;  // 1 + sine in Q1.14, 0..32768
  localparam int HALF_W  = 8;   // half the grid size
  localparam int SCALE_W = 24;  // level product before the Q14 shift

  // Angle landmarks in degrees.
  localparam logic [ANGLE_W-1:0] ANG_QUARTER = 9'd90;
  localparam logic [ANGLE_W-1:0] ANG_HALF    = 9'd180;
  localparam logic [ANGLE_W-1:0] ANG_THREE_Q = 9'd270;
  localparam logic [ANGLE_W-1:0] ANG_FULL    = 9'd360;
  localparam int                 COS_LAST    = 90;

  // Geometry: the center column swings around 128 and the row sits at 128.
  localparam logic signed [DX_W-1:0] CENTER_COL_Q8 = 18'sd32768;
  localparam logic [HALF_W-1:0]      CENTER_ROW    = 8'd128;

  // Fixed-point constants.
  localparam logic [63:0]        PI_Q30   = 64'd3373259426;
  localparam logic [MAG_W-1:0]   ONE_Q14  = 15'd16384;
  localparam logic [SUM_W-1:0]   ONE_SUM  = 16'd16384;

  typedef logic [MAG_W-1:0] cos_table_t [0:COS_LAST];

  // Sine of a Q30 angle by a seven-term Taylor series in 64-bit arithmetic.
  function automatic logic [63:0] sin_q30(input logic [63:0] th);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = (th * th) >> 30;
    term = th;
    sum  = th;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    return sum;
  endfunction

  // Rounds a Q30 sine to Q14 and caps it at one.
  function automatic logic [MAG_W-1:0] q14_of(input logic [63:0] th);
    logic [63:0] s;
    s = (sin_q30(th) + 64'd32768) >> 16;
    if (s > 64'(ONE_Q14)) begin
      s = 64'(ONE_Q14);
    end
    return MAG_W'(s);
  endfunction

  // Quarter-wave cosine, one entry per degree from 0 to 90.
  function automatic cos_table_t build_cos_table();
    cos_table_t t;
    logic [63:0] th;
    for (int d = 0; d <= COS_LAST; d++) begin
      th   = 64'(COS_LAST - d) * PI_Q30 / 64'd180;
      t[d] = q14_of(th);
    end
    return t;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* rtl/core/ppl_isqrt.sv */
// Pipelined floor square root: one root bit is settled in each register stage.
module ppl_isqrt #(
  parameter int RAD_BITS = 34,
  localparam int ROOT_BITS = RAD_BITS / 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  radicand,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] root
);

  localparam int REM_BITS = ROOT_BITS + 3;

  logic                 valid_s [0:ROOT_BITS-1];
  logic [REM_BITS-1:0]  rem_s   [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_s  [0:ROOT_BITS-1];
  logic [RAD_BITS-1:0]  rad_s   [0:ROOT_BITS-1];

  // The first step starts from an empty root and remainder.
  assign valid_s[0] = in_valid;
  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign rad_s[0]   = radicand;

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    logic [REM_BITS-1:0]  rem_sh;
    logic [REM_BITS-1:0]  trial;
    logic [ROOT_BITS-1:0] root_new;
    logic                 fit;

    // Bring down the next two radicand bits and try a one in the root.
    always_comb begin
      rem_sh   = {rem_s[i][REM_BITS-3:0], rad_s[i][RAD_BITS-1 -: 2]};
      trial    = REM_BITS'({root_s[i], 2'b01});
      fit      = (rem_sh >= trial);
      root_new = {root_s[i][ROOT_BITS-2:0], fit};
    end

    if (i < ROOT_BITS - 1) begin : g_mid
      logic [REM_BITS-1:0] rem_new;

      assign rem_new = fit ? (rem_sh - trial) : rem_sh;

      // Stage valid bit.
      always_ff @(posedge clk) begin
        if (rst) begin
          valid_s[i+1] <= 1'b0;
        end else begin
          valid_s[i+1] <= valid_s[i];
        end
      end

      // Stage payload.
      always_ff @(posedge clk) begin
        rem_s[i+1]  <= rem_new;
        root_s[i+1] <= root_new;
        rad_s[i+1]  <= {rad_s[i][RAD_BITS-3:0], 2'b00};
      end
    end else begin : g_last
      // Last step drives the result registers.
      always_ff @(posedge clk) begin
        if (rst) begin
          out_valid <= 1'b0;
        end else begin
          out_valid <= valid_s[i];
        end
      end

      always_ff @(posedge clk) begin
        root <= root_new;
      end
    end
  end

endmodule

/* rtl/core/plasma_pixel_level.sv */
// Plasma pixel level: one pixel request (column, row, frame angle) gives one
// level of 32 + 32*sin(distance to a moving center), in a fixed pipeline.
// A request is taken in every clock cycle in which start is high; busy is
// always low. The level appears on level with done high for exactly one
// cycle, and results come out in request order. The pipeline has six stages
// for the angle fold, cosine table and squared distance, seventeen stages of
// the square root (one root bit each), and eight stages for the phase
// division by 2*pi, the sine table and the output scaling. The receiver
// cannot stall the block, so it must take done and level when they appear.
module plasma_pixel_level
  import ppl_pkg::*;
#(
  parameter int GRID_SIZE        = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [COL_W-1:0]   pixel_column,
  input  logic [ROW_W-1:0]   pixel_row,
  input  logic [ANGLE_W-1:0] frame_angle,
  output logic               done,
  output logic [LEVEL_W-1:0] level
);

  // Phase arithmetic derived from the sine table depth (a power of two).
  localparam int SINE_AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int QUART_AW = SINE_AW - 2;
  localparam int QUARTER  = SINE_TABLE_DEPTH / 4;
  localparam int SHIFT_S  = 21 + SINE_AW;
  localparam int RECIP_K  = 24;
  localparam int RECIP_W  = SINE_AW + 14;
  localparam int PROD_W   = DIST_W + RECIP_W;
  localparam int NUM_W    = DIST_W + SHIFT_S;
  localparam logic [63:0]        RECIP_FULL = (64'd1 << (SHIFT_S + RECIP_K)) / PI_Q30;
  localparam logic [RECIP_W-1:0] RECIP_M    = RECIP_FULL[RECIP_W-1:0];
  localparam logic [RES_W-1:0]   PI_RES     = PI_Q30[RES_W-1:0];
  localparam logic [SINE_AW-2:0] QUARTER_V  = (SINE_AW - 1)'(QUARTER);
  localparam logic [HALF_W-1:0]  HALF       = HALF_W'(GRID_SIZE / 2);

  typedef logic [MAG_W-1:0] quarter_table_t [0:QUARTER-1];

  // Quarter-wave sine: entry j is sin(2*j*pi/N) for the first quadrant.
  function automatic quarter_table_t build_sine_quarter();
    quarter_table_t t;
    logic [63:0] th;
    for (int j = 0; j < QUARTER; j++) begin
      th   = 64'(2 * j) * PI_Q30 / 64'(SINE_TABLE_DEPTH);
      t[j] = q14_of(th);
    end
    return t;
  endfunction

  localparam quarter_table_t SINE_QUARTER = build_sine_quarter();

  logic take;

  // Stage registers.
  logic                      st1_valid, st2_valid, st3_valid;
  logic                      st4_valid, st5_valid, st6_valid;
  logic [ANGLE_W-1:0]        st1_ang;
  logic [COL_W-1:0]          st1_col, st2_col, st3_col;
  logic [ROW_W-1:0]          st1_row, st2_row, st3_row;
  logic [DEG_W-1:0]          st2_deg;
  logic                      st2_neg;
  logic signed [COS_W-1:0]   st3_cos;
  logic signed [DX_W-1:0]    st4_dx;
  logic [DY_W-1:0]           st4_dy;
  logic [DXSQ_W-1:0]         st5_dx_sq;
  logic [DYSQ_W-1:0]         st5_dy_sq;
  logic [RAD_W-1:0]          st6_d2;

  logic                      root_valid;
  logic [DIST_W-1:0]         root;

  logic                      mul_valid, fix_valid, rem_valid, phase_valid;
  logic                      fold_valid, sine_valid, sum_valid;
  logic [DIST_W-1:0]         mul_dist, fix_dist;
  logic [PROD_W-1:0]         mul_prod;
  logic [RES_W-1:0]          fix_q0p;
  logic [SINE_AW-1:0]        fix_q0, rem_q0;
  logic [RES_W-1:0]          rem_res;
  logic [SINE_AW-1:0]        phase;
  logic [QUART_AW-1:0]       fold_idx;
  logic                      fold_peak, fold_neg;
  logic [MAG_W-1:0]          sine_mag;
  logic                      sine_neg;
  logic [SUM_W-1:0]          sum_u;

  // Combinational helpers.
  logic [ANGLE_W-1:0]        ang_red;
  logic [ANGLE_W-1:0]        fold_deg;
  logic                      fold_deg_neg;
  logic [COS_W-1:0]          cos_mag;
  logic signed [DX_W-1:0]    cos_ext, col_term;
  logic [HALF_W-1:0]         row_off;
  logic signed [2*DX_W-1:0]  dx_prod;
  logic [DXSQ_W:0]           d2_sum;
  logic [PROD_W-RECIP_K-1:0] q0_full;
  logic [NUM_W-1:0]          num;
  logic [SINE_AW-2:0]        idx_full;
  logic [SCALE_W-1:0]        scale;

  // The pipeline never stalls, so a request is taken whenever start is high.
  assign busy = 1'b0;
  assign take = start && !busy;

  // Datapath between the stages.
  always_comb begin
    ang_red = (frame_angle >= ANG_FULL) ? (frame_angle - ANG_FULL) : frame_angle;

    // Fold the angle onto the quarter-wave cosine table.
    if (st1_ang <= ANG_QUARTER) begin
      fold_deg     = st1_ang;
      fold_deg_neg = 1'b0;
    end else if (st1_ang <= ANG_HALF) begin
      fold_deg     = ANG_HALF - st1_ang;
      fold_deg_neg = 1'b1;
    end else if (st1_ang <= ANG_THREE_Q) begin
      fold_deg     = st1_ang - ANG_HALF;
      fold_deg_neg = 1'b1;
    end else begin
      fold_deg     = ANG_FULL - st1_ang;
      fold_deg_neg = 1'b0;
    end

    cos_mag = COS_W'(COS_TABLE[st2_deg]);

    // Offsets to the center in Q8: the center column is 32768 + 2*cos.
    cos_ext  = DX_W'(st3_cos);
    col_term = signed'({4'b0000, st3_col, 8'h00});
    row_off  = CENTER_ROW - HALF_W'(st3_row);

    dx_prod = st4_dx * st4_dx;
    d2_sum  = (DXSQ_W + 1)'(st5_dx_sq) + (DXSQ_W + 1)'(st5_dy_sq);

    // Phase = floor(dist * 2^SHIFT_S / pi_q30) by reciprocal and correction.
    q0_full = mul_prod[PROD_W-1:RECIP_K];
    num     = NUM_W'(fix_dist) << SHIFT_S;

    // Fold the phase onto the quarter-wave sine table.
    if (phase[SINE_AW-2]) begin
      idx_full = QUARTER_V - {1'b0, phase[QUART_AW-1:0]};
    end else begin
      idx_full = {1'b0, phase[QUART_AW-1:0]};
    end

    scale = SCALE_W'(HALF) * SCALE_W'(sum_u);
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid   <= 1'b0;
      st2_valid   <= 1'b0;
      st3_valid   <= 1'b0;
      st4_valid   <= 1'b0;
      st5_valid   <= 1'b0;
      st6_valid   <= 1'b0;
      mul_valid   <= 1'b0;
      fix_valid   <= 1'b0;
      rem_valid   <= 1'b0;
      phase_valid <= 1'b0;
      fold_valid  <= 1'b0;
      sine_valid  <= 1'b0;
      sum_valid   <= 1'b0;
      done        <= 1'b0;
    end else begin
      st1_valid   <= take;
      st2_valid   <= st1_valid;
      st3_valid   <= st2_valid;
      st4_valid   <= st3_valid;
      st5_valid   <= st4_valid;
      st6_valid   <= st5_valid;
      mul_valid   <= root_valid;
      fix_valid   <= mul_valid;
      rem_valid   <= fix_valid;
      phase_valid <= rem_valid;
      fold_valid  <= phase_valid;
      sine_valid  <= fold_valid;
      sum_valid   <= sine_valid;
      done        <= sum_valid;
    end
  end

  // Payload registers of the geometry stages.
  always_ff @(posedge clk) begin
    st1_ang   <= ang_red;
    st1_col   <= pixel_column;
    st1_row   <= pixel_row;
    st2_deg   <= DEG_W'(fold_deg);
    st2_neg   <= fold_deg_neg;
    st2_col   <= st1_col;
    st2_row   <= st1_row;
    st3_cos   <= st2_neg ? -signed'(cos_mag) : signed'(cos_mag);
    st3_col   <= st2_col;
    st3_row   <= st2_row;
    st4_dx    <= CENTER_COL_Q8 - col_term + (cos_ext <<< 1);
    st4_dy    <= {row_off, 8'h00};
    st5_dx_sq <= dx_prod[DXSQ_W-1:0];
    st5_dy_sq <= st4_dy * st4_dy;
    st6_d2    <= RAD_W'(d2_sum);
  end

  // Distance in Q9.8.
  ppl_isqrt #(
    .RAD_BITS (RAD_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st6_valid),
    .radicand  (st6_d2),
    .out_valid (root_valid),
    .root      (root)
  );

  // Payload registers of the phase, sine and level stages.
  always_ff @(posedge clk) begin
    mul_dist  <= root;
    mul_prod  <= PROD_W'(root) * PROD_W'(RECIP_M);
    fix_dist  <= mul_dist;
    fix_q0    <= q0_full[SINE_AW-1:0];
    fix_q0p   <= RES_W'(RES_W'(q0_full) * PI_RES);
    rem_res   <= num[RES_W-1:0] - fix_q0p;
    rem_q0    <= fix_q0;
    phase     <= rem_q0 + SINE_AW'(rem_res >= PI_RES);
    fold_idx  <= idx_full[QUART_AW-1:0];
    fold_peak <= idx_full[SINE_AW-2];
    fold_neg  <= phase[SINE_AW-1];
    sine_mag  <= fold_peak ? ONE_Q14 : SINE_QUARTER[fold_idx];
    sine_neg  <= fold_neg;
    sum_u     <= sine_neg ? (ONE_SUM - SUM_W'(sine_mag)) : (ONE_SUM + SUM_W'(sine_mag));
    level     <= scale[FRAC_W +: LEVEL_W];
  end

endmodule

/* dv/plasma_pixel_level_checker.sv */
module plasma_pixel_level_checker
#(
  parameter int GRID_SIZE        = 64,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [ppl_pkg::COL_W-1:0]   pixel_column,
  input  logic [ppl_pkg::ROW_W-1:0]   pixel_row,
  input  logic [ppl_pkg::ANGLE_W-1:0] frame_angle,
  input  logic                        done,
  input  logic [ppl_pkg::LEVEL_W-1:0] level,
  output int                          mismatch_count,
  output int                          levels_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Pi in Q30 and the fixed geometry of the moving center.
  localparam logic [63:0] HALF_TURN_Q30 = 64'd3373259426;
  localparam longint      UNIT_Q14      = 16384;
  localparam longint      SWING_BASE    = 128;
  localparam longint      ROW_CENTER    = 128;

  logic [ppl_pkg::LEVEL_W-1:0] expected_levels [$];
  logic [ppl_pkg::LEVEL_W-1:0] oldest_level;

  // Seven-term Taylor series for the sine of a Q30 angle, wrapping at 64 bits.
  function automatic logic [63:0] taylor_sin_q30(input logic [63:0] theta);
    logic [63:0] sq;
    logic [63:0] term;
    logic [63:0] acc;
    sq   = (theta * theta) >> 30;
    term = theta;
    acc  = theta;
    for (int k = 1; k <= 6; k++) begin
      term = (term * sq) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  // Rounds the Q30 sine to Q14, never above one.
  function automatic longint sine_q14(input logic [63:0] theta);
    logic [63:0] r;
    r = (taylor_sin_q30(theta) + 64'd32768) >> 16;
    if (r > 64'(UNIT_Q14)) begin
      r = 64'(UNIT_Q14);
    end
    return longint'(r);
  endfunction

  function automatic longint quarter_wave_cos(input int deg);
    int d;
    d = (deg > 90) ? 90 : deg;
    return sine_q14(64'(90 - d) * HALF_TURN_Q30 / 64'd180);
  endfunction

  // Cosine of a whole degree in 0..359, folded onto the quarter wave.
  function automatic longint cos_of_degree(input int deg);
    if (deg <= 90) begin
      return quarter_wave_cos(deg);
    end
    if (deg <= 180) begin
      return -quarter_wave_cos(180 - deg);
    end
    if (deg <= 270) begin
      return -quarter_wave_cos(deg - 180);
    end
    return quarter_wave_cos(360 - deg);
  endfunction

  // Full-wave sine table entry, built from the quarter-wave fold.
  function automatic longint sine_of_index(input logic [63:0] index);
    logic [63:0] depth;
    logic [63:0] k;
    logic [63:0] m;
    logic        negative;
    longint      s;
    depth    = 64'(SINE_TABLE_DEPTH);
    k        = index % depth;
    negative = 1'b0;
    if (4 * k <= depth) begin
      m = 2 * k;
    end else if (4 * k <= 2 * depth) begin
      m = depth - 2 * k;
    end else if (4 * k <= 3 * depth) begin
      m = 2 * k - depth;
      negative = 1'b1;
    end else begin
      m = 2 * depth - 2 * k;
      negative = 1'b1;
    end
    s = sine_q14(m * HALF_TURN_Q30 / depth);
    return negative ? -s : s;
  endfunction

  // Floored integer square root, two bits of the radicand per step.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = radicand;
    root  = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) begin
      probe = probe >> 2;
    end
    while (probe != 64'd0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Expected plasma level for one pixel request.
  function automatic logic [ppl_pkg::LEVEL_W-1:0] predict_level(
    input logic [ppl_pkg::COL_W-1:0]   col,
    input logic [ppl_pkg::ROW_W-1:0]   row,
    input logic [ppl_pkg::ANGLE_W-1:0] angle
  );
    int          deg;
    longint      center_q8;
    longint      dx;
    longint      dy;
    logic [63:0] dist_sq;
    logic [63:0] dist_q8;
    logic [63:0] phase;
    longint      scaled;
    deg = int'(angle);
    if (deg >= 360) begin
      deg = deg - 360;
    end
    center_q8 = (SWING_BASE * UNIT_Q14 + SWING_BASE * cos_of_degree(deg)) / 64;
    dx        = center_q8 - longint'(col) * 256;
    dy        = (ROW_CENTER - longint'(row)) * 256;
    dist_sq   = 64'(dx * dx + dy * dy);
    dist_q8   = floor_sqrt(dist_sq);
    phase     = ((dist_q8 * 64'(SINE_TABLE_DEPTH)) << 21) / HALF_TURN_Q30;
    phase     = phase % 64'(SINE_TABLE_DEPTH);
    scaled    = longint'(GRID_SIZE / 2) * (UNIT_Q14 + sine_of_index(phase));
    return ppl_pkg::LEVEL_W'(scaled >> 14);
  endfunction

  // Retire each result against the oldest request, then record a new request.
  always @(posedge clk) begin
    if (rst) begin
      expected_levels.delete();
    end else begin
      if (done) begin
        if (expected_levels.size() == 0) begin
          $error("level: expected none, actual %0d", level);
          mismatch_count++;
        end else begin
          oldest_level = expected_levels.pop_front();
          if (level !== oldest_level) begin
            $error("level: expected %0d, actual %0d", oldest_level, level);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_levels.push_back(predict_level(pixel_column, pixel_row, frame_angle));
      end
    end
    levels_outstanding = expected_levels.size();
  end

endmodule

/* dv/plasma_pixel_level_tb.sv */
module plasma_pixel_level_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 1300;
  localparam int SETTLE_CYCLES   = 40;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [ppl_pkg::COL_W-1:0]   pixel_column;
  logic [ppl_pkg::ROW_W-1:0]   pixel_row;
  logic [ppl_pkg::ANGLE_W-1:0] frame_angle;
  logic                        done;
  logic [ppl_pkg::LEVEL_W-1:0] level;
  int                          mismatches;
  int                          outstanding;
  int                          sent;
  int                          burst;

  plasma_pixel_level dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_column (pixel_column),
    .pixel_row    (pixel_row),
    .frame_angle  (frame_angle),
    .done         (done),
    .level        (level)
  );

  plasma_pixel_level_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .pixel_column       (pixel_column),
    .pixel_row          (pixel_row),
    .frame_angle        (frame_angle),
    .done               (done),
    .level              (level),
    .mismatch_count     (mismatches),
    .levels_outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Present one request and hold it until the block takes it.
  task automatic send_request(input int col, input int row, input int angle);
    @(negedge clk);
    start        <= 1'b1;
    pixel_column <= ppl_pkg::COL_W'(col);
    pixel_row    <= ppl_pkg::ROW_W'(row);
    frame_angle  <= ppl_pkg::ANGLE_W'(angle);
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // Idle cycles with junk on the fields, which the block must ignore.
  task automatic idle_cycles(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      pixel_column <= ppl_pkg::COL_W'($urandom);
      pixel_row    <= ppl_pkg::ROW_W'($urandom);
      frame_angle  <= ppl_pkg::ANGLE_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Hold off new requests until every pending level has come back.
  task automatic drain_levels();
    idle_cycles(1);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    pixel_column = '0;
    pixel_row    = '0;
    frame_angle  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Corners of the map, the quarter-wave landmarks and angles of 360 and above.
    send_request(0, 0, 0);
    send_request(63, 63, 0);
    send_request(0, 63, 90);
    send_request(63, 0, 180);
    send_request(0, 63, 180);
    send_request(32, 32, 270);
    send_request(63, 63, 359);
    send_request(0, 0, 360);
    send_request(17, 40, 511);
    send_request(0, 0, 511);
    send_request(63, 0, 450);
    send_request(1, 2, 1);
    send_request(62, 61, 89);
    send_request(5, 6, 91);
    send_request(7, 8, 179);
    send_request(9, 10, 181);
    send_request(11, 12, 269);
    send_request(13, 14, 271);
    send_request(21, 42, 45);
    send_request(42, 21, 405);
    send_request(31, 31, 300);
    send_request(63, 63, 256);
    send_request(32, 0, 361);
    drain_levels();

    // Random requests over the full field ranges, in bursts with random gaps.
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && sent < RANDOM_REQUESTS; i++) begin
        send_request($urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 511));
        sent++;
        if (sent == RANDOM_REQUESTS / 2) begin
          drain_levels();
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 8));
      end
    end

    drain_levels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("plasma_pixel_level_tb: clean");
    end else begin
      $display("plasma_pixel_level_tb: errors");
    end
    $finish;
  end

  // Watchdog in case the results stop coming.
  initial begin
    #1000000;
    $display("plasma_pixel_level_tb: errors");
    $finish;
  end

endmodule
